// File: src/reward_eligibility_weight_update_defines.svh
// ----------------------------------------------------------------------------
// reward eligibility weight update: assertion macros
// wraps concurrent assertions so that synthesis sees empty bodies
// ----------------------------------------------------------------------------
`ifndef REWARD_ELIGIBILITY_WEIGHT_UPDATE_DEFINES_SVH
`define REWARD_ELIGIBILITY_WEIGHT_UPDATE_DEFINES_SVH

`ifndef SYNTHESIS
`define REWU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rewu assertion failed");
`define REWU_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rewu forbidden condition seen");
`else
`define REWU_ASSERT(label, clk, rst_n, prop)
`define REWU_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: src/rewu_pkg.sv
// ----------------------------------------------------------------------------
// rewu_pkg
// types, constants and codes shared by the reward eligibility weight update
// ----------------------------------------------------------------------------
package rewu_pkg;

    localparam int SYNAPSE_SLOTS = 32;
    localparam int SLOT_AW = (SYNAPSE_SLOTS > 1) ? $clog2(SYNAPSE_SLOTS) : 1;

    // 0.3 in q0.16, dopamine ceiling 1.0 in q1.15
    localparam logic [15:0] DA_GAIN = 16'd19661;
    localparam logic [15:0] DA_MAX  = 16'd32768;

    localparam logic        RST_ENABLE    = 1'b1;
    localparam logic [15:0] RST_RATE      = 16'd655;
    localparam logic [14:0] RST_THRESHOLD = 15'd41;
    localparam logic [15:0] RST_DECAY     = 16'd62259;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_REWARD = 1'b1;

    typedef enum logic [1:0] {
        CFG_ENABLE    = 2'd0,
        CFG_RATE      = 2'd1,
        CFG_THRESHOLD = 2'd2,
        CFG_DECAY     = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        EV_LTP  = 2'd0,
        EV_LTD  = 2'd1,
        EV_DONE = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic               opcode;
        logic [4:0]         entry_index;
        logic               entry_active;
        logic signed [15:0] entry_weight;
        logic signed [15:0] entry_wmin;
        logic signed [15:0] entry_wmax;
        logic signed [15:0] entry_trace;
        logic signed [15:0] reward_value;
    } item_t;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [4:0]         slot;
        logic signed [15:0] weight_before;
        logic signed [15:0] weight_after;
        logic [15:0]        dopamine_level;
        logic               last;
    } result_t;

    typedef struct packed {
        logic signed [15:0] weight;
        logic signed [15:0] wmin;
        logic signed [15:0] wmax;
        logic signed [15:0] trace;
    } entry_t;

    typedef struct packed {
        logic               load;
        logic               take_reward;
        logic               da_mul;
        logic               da_add;
        logic               issue;
        logic [SLOT_AW-1:0] addr;
        logic               emit_done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic adv;
        logic busy;
        logic enable;
    } ctrl_status_t;

endpackage

// File: src/rewu_ctrl.sv
// ----------------------------------------------------------------------------
// rewu_ctrl
// sequencer: load writes, dopamine update, slot sweep and done transfer
// ----------------------------------------------------------------------------
module rewu_ctrl
    import rewu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  logic         opcode,
    output logic         item_stall,
    output ctrl_cmd_t    cmd,
    input  ctrl_status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DA_MUL,
        S_DA_ADD,
        S_SWEEP,
        S_DRAIN
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [SLOT_AW-1:0] cnt_reg;
    logic [SLOT_AW-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.addr   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (opcode == OP_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.take_reward = 1'b1;
                        state_next      = S_DA_MUL;
                    end
                end
            end
            S_DA_MUL:
            begin
                cmd.da_mul = 1'b1;
                state_next = S_DA_ADD;
            end
            S_DA_ADD:
            begin
                cmd.da_add = 1'b1;
                cnt_next   = '0;
                state_next = status.enable ? S_SWEEP : S_DRAIN;
            end
            S_SWEEP:
            begin
                if (status.adv)
                begin
                    cmd.issue = 1'b1;
                    if (cnt_reg == SLOT_AW'(SYNAPSE_SLOTS - 1))
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_DRAIN:
            begin
                if (!status.busy && status.adv)
                begin
                    cmd.emit_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);

endmodule

// File: src/rewu_dp.sv
// ----------------------------------------------------------------------------
// rewu_dp
// slot table, dopamine arithmetic, update pipeline and output register
// ----------------------------------------------------------------------------
module rewu_dp
    import rewu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  item_t        item,
    input  ctrl_cmd_t    cmd,
    output ctrl_status_t status,
    input  logic         cfg_valid,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    output logic         result_valid,
    output result_t      result,
    input  logic         result_stall
);

    // configuration
    logic        enable_reg;
    logic [15:0] rate_reg;
    logic [14:0] thresh_reg;
    logic [15:0] decay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= RST_ENABLE;
            rate_reg   <= RST_RATE;
            thresh_reg <= RST_THRESHOLD;
            decay_reg  <= RST_DECAY;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ENABLE:    enable_reg <= cfg_data[0];
                CFG_RATE:      rate_reg   <= cfg_data;
                CFG_THRESHOLD: thresh_reg <= cfg_data[14:0];
                CFG_DECAY:     decay_reg  <= cfg_data;
                default:       enable_reg <= enable_reg;
            endcase
        end
    end

    // reward and dopamine
    logic signed [15:0] reward_reg;
    logic signed [32:0] da_prod_reg;
    logic signed [32:0] rl_reg;
    logic [15:0]        dopamine_reg;
    logic signed [32:0] da_rnd;
    logic signed [32:0] da_sum;
    logic [15:0]        da_next;
    logic signed [16:0] gain_s;
    logic signed [16:0] rate_s;

    assign gain_s = signed'({1'b0, DA_GAIN});
    assign rate_s = signed'({1'b0, rate_reg});

    always_comb
    begin
        da_rnd = (da_prod_reg + 33'sd4096) >>> 13;
        da_sum = da_rnd + signed'({17'd0, dopamine_reg});
        if (da_sum < 33'sd0)
        begin
            da_next = '0;
        end
        else if (da_sum > signed'({17'd0, DA_MAX}))
        begin
            da_next = DA_MAX;
        end
        else
        begin
            da_next = da_sum[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_reward)
        begin
            reward_reg <= item.reward_value;
        end
        if (cmd.da_mul)
        begin
            da_prod_reg <= reward_reg * gain_s;
        end
        if (cmd.da_add)
        begin
            rl_reg <= reward_reg * rate_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dopamine_reg <= '0;
        end
        else if (cmd.da_add)
        begin
            dopamine_reg <= da_next;
        end
    end

    // slot table
    entry_t             mem [SYNAPSE_SLOTS];
    logic [SYNAPSE_SLOTS-1:0] active_reg;
    logic               load_ok;
    logic               mem_we;
    logic [SLOT_AW-1:0] mem_waddr;
    entry_t             mem_wdata;
    logic               adv;

    // pipeline registers
    logic               s1_valid_reg;
    logic [SLOT_AW-1:0] s1_slot_reg;
    entry_t             s1_entry_reg;
    logic               s2_valid_reg;
    logic [SLOT_AW-1:0] s2_slot_reg;
    logic signed [15:0] s2_weight_reg;
    logic signed [15:0] s2_wmin_reg;
    logic signed [15:0] s2_wmax_reg;
    logic signed [48:0] s2_dw_prod_reg;
    logic signed [32:0] s2_tr_prod_reg;
    logic               s3_valid_reg;
    logic [SLOT_AW-1:0] s3_slot_reg;
    logic signed [15:0] s3_weight_reg;
    logic signed [15:0] s3_wmin_reg;
    logic signed [15:0] s3_wmax_reg;
    logic signed [15:0] s3_dw_reg;
    logic signed [15:0] s3_trace_reg;

    logic [15:0]        s1_mag;
    logic               s1_hit;
    logic signed [16:0] decay_s;
    logic signed [48:0] dw_rnd;
    logic signed [15:0] dw_sat;
    logic signed [32:0] tr_rnd;
    logic signed [16:0] w_sum;
    logic signed [15:0] w_after;
    logic               slot_fire;

    assign load_ok = cmd.load && (int'(item.entry_index) < SYNAPSE_SLOTS);
    assign adv     = !result_valid || !result_stall;
    assign decay_s = signed'({1'b0, decay_reg});

    always_comb
    begin
        s1_mag = s1_entry_reg.trace[15] ? (~s1_entry_reg.trace + 16'd1)
                                        : s1_entry_reg.trace;
        s1_hit = s1_valid_reg && (s1_mag > {1'b0, thresh_reg});
    end

    always_comb
    begin
        dw_rnd = (s2_dw_prod_reg + 49'sd134217728) >>> 28;
        if (dw_rnd > 49'sd32767)
        begin
            dw_sat = 16'sh7fff;
        end
        else if (dw_rnd < -49'sd32768)
        begin
            dw_sat = 16'sh8000;
        end
        else
        begin
            dw_sat = dw_rnd[15:0];
        end
        tr_rnd = (s2_tr_prod_reg + 33'sd32768) >>> 16;
    end

    always_comb
    begin
        w_sum = {s3_weight_reg[15], s3_weight_reg} + {s3_dw_reg[15], s3_dw_reg};
        if (w_sum > signed'({s3_wmax_reg[15], s3_wmax_reg}))
        begin
            w_sum = {s3_wmax_reg[15], s3_wmax_reg};
        end
        if (w_sum < signed'({s3_wmin_reg[15], s3_wmin_reg}))
        begin
            w_sum = {s3_wmin_reg[15], s3_wmin_reg};
        end
        w_after   = w_sum[15:0];
        slot_fire = s3_valid_reg && (s3_dw_reg != 16'sd0);
    end

    always_comb
    begin
        if (load_ok)
        begin
            mem_we    = 1'b1;
            mem_waddr = SLOT_AW'(item.entry_index);
            mem_wdata = '{weight: item.entry_weight, wmin: item.entry_wmin,
                          wmax: item.entry_wmax, trace: item.entry_trace};
        end
        else
        begin
            mem_we    = adv && s3_valid_reg;
            mem_waddr = s3_slot_reg;
            mem_wdata = '{weight: w_after, wmin: s3_wmin_reg,
                          wmax: s3_wmax_reg, trace: s3_trace_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (load_ok)
        begin
            active_reg[SLOT_AW'(item.entry_index)] <= item.entry_active;
        end
    end

    // pipeline payload, frozen while the output register is held
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_slot_reg    <= cmd.addr;
            s1_entry_reg   <= mem[cmd.addr];
            s2_slot_reg    <= s1_slot_reg;
            s2_weight_reg  <= s1_entry_reg.weight;
            s2_wmin_reg    <= s1_entry_reg.wmin;
            s2_wmax_reg    <= s1_entry_reg.wmax;
            s2_dw_prod_reg <= s1_entry_reg.trace * rl_reg;
            s2_tr_prod_reg <= s1_entry_reg.trace * decay_s;
            s3_slot_reg    <= s2_slot_reg;
            s3_weight_reg  <= s2_weight_reg;
            s3_wmin_reg    <= s2_wmin_reg;
            s3_wmax_reg    <= s2_wmax_reg;
            s3_dw_reg      <= dw_sat;
            s3_trace_reg   <= tr_rnd[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= cmd.issue && active_reg[cmd.addr];
            s2_valid_reg <= s1_hit;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // output register
    logic    result_valid_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= slot_fire || cmd.emit_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && slot_fire)
        begin
            result_reg.event_kind     <= (s3_dw_reg > 16'sd0) ? EV_LTP : EV_LTD;
            result_reg.slot           <= 5'(s3_slot_reg);
            result_reg.weight_before  <= s3_weight_reg;
            result_reg.weight_after   <= w_after;
            result_reg.dopamine_level <= dopamine_reg;
            result_reg.last           <= 1'b0;
        end
        else if (adv && cmd.emit_done)
        begin
            result_reg.event_kind     <= EV_DONE;
            result_reg.slot           <= '0;
            result_reg.weight_before  <= '0;
            result_reg.weight_after   <= '0;
            result_reg.dopamine_level <= dopamine_reg;
            result_reg.last           <= 1'b1;
        end
    end

    assign result_valid  = result_valid_reg;
    assign result        = result_reg;
    assign status.adv    = adv;
    assign status.busy   = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign status.enable = enable_reg;

endmodule

// File: src/reward_eligibility_weight_update.sv
// ----------------------------------------------------------------------------
// reward_eligibility_weight_update
// reward-modulated eligibility trace weight update over a synapse slot table
// ----------------------------------------------------------------------------
// item channel (item_valid / item_stall / item): opcode 0 loads one slot and
// gives no result; opcode 1 applies a reward. A reward runs the dopamine
// update (multiply, then add), sweeps the slots through a three-stage
// pipeline, one per cycle while the result channel is not stalled, waits for
// the pipeline to empty and then loads the done transfer; only then is the
// next item accepted. With eligibility off the sweep is skipped and the done
// transfer follows the dopamine update. item_stall stays high until the done
// result has been loaded into the output register.
// result channel (result_valid / result_stall / result): one potentiation or
// depression transfer per updated slot with nonzero change, in slot order,
// then one done transfer with last set. While result_stall holds a waiting
// result, the whole pipeline and the sweep counter hold too, and nothing is
// lost; a stall lengthens the reward.
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready.
// The user must write it only while the block is idle; the block does not
// enforce this. reset: registers take their reset values, every slot is
// inactive and the dopamine level is zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "reward_eligibility_weight_update_defines.svh"

module reward_eligibility_weight_update
    import rewu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    logic         reward_take;
    logic         result_done;

    assign cfg_ready   = 1'b1;
    assign reward_take = item_valid && !item_stall && (item.opcode == OP_REWARD);
    assign result_done = (result.event_kind == EV_DONE);

    rewu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .opcode     (item.opcode),
        .item_stall (item_stall),
        .cmd        (cmd),
        .status     (status)
    );

    rewu_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

    `REWU_ASSERT(a_reward_blocks, clk, rst_n, reward_take |=> item_stall)
    `REWU_ASSERT(a_last_is_done, clk, rst_n, result_valid |-> (result.last == result_done))
    `REWU_NEVER(a_dopamine_range, clk, rst_n, result_valid && (result.dopamine_level > DA_MAX))

endmodule
